@@ src/serial_pixel_command_framer_defines.svh @@
// Assertion macros for the serial pixel command framer.
`ifndef SERIAL_PIXEL_COMMAND_FRAMER_DEFINES_SVH
`define SERIAL_PIXEL_COMMAND_FRAMER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define SPCF_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define SPCF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/spcf_pkg.sv @@
// Shared types and constants for the serial pixel command framer.
package spcf_pkg;

	localparam int PACKET_CAPACITY_DEF = 16;
	localparam int FRAME_WIDTH_DEF     = 8;
	localparam int FRAME_HEIGHT_DEF    = 8;

	localparam logic [7:0] CMD_START   = 8'd0;
	localparam logic [7:0] CMD_READOUT = 8'd1;
	localparam logic [7:0] CMD_SET     = 8'd2;

	typedef enum logic [1:0] {
		KIND_ACK   = 2'd0,
		KIND_BAD   = 2'd1,
		KIND_PIXEL = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHECK,
		ST_WRITE,
		ST_ACK,
		ST_RDADDR,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		AOP_HOLD,
		AOP_ZERO,
		AOP_LOAD,
		AOP_STEP
	} aop_t;

	typedef struct packed {
		logic  rx_ready;
		logic  pos_clr;
		logic  mem_we;
		logic  mem_zero;
		logic  mem_re;
		aop_t  aop;
		logic  out_load;
		kind_t out_kind;
		logic  out_final;
	} ctl_t;

endpackage

@@ src/serial_pixel_command_framer.sv @@
// A byte that completes no packet passes transfer and check; a completing byte with
// command 0, 2 or unknown gives its acknowledge from ACK (command 2 via WRITE) once the
// output slot is free. Readout: 64 pixel results, each read in RDADDR and given in EMIT,
// paced by the single frame memory port. Bytes are taken only in IDLE; rx_ready stays low
// while a packet is dispatched. Reset: async, active low; packet store and position clear
// at once, then a sweep of FRAME_WIDTH*FRAME_HEIGHT addresses (64 by default) zeroes memory.
`include "serial_pixel_command_framer_defines.svh"

module serial_pixel_command_framer import spcf_pkg::*; #(
	parameter int PACKET_CAPACITY = PACKET_CAPACITY_DEF,
	parameter int FRAME_WIDTH     = FRAME_WIDTH_DEF,
	parameter int FRAME_HEIGHT    = FRAME_HEIGHT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rx_valid,
	output logic        rx_ready,
	input  logic [7:0]  rx_byte,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [1:0]  kind,
	output logic [2:0]  pixel_x,
	output logic [2:0]  pixel_y,
	output logic [23:0] pixel_color,
	output logic        acknowledge,
	output logic        last
);

	localparam int FRAME_SIZE = FRAME_WIDTH * FRAME_HEIGHT;
	localparam int AW = $clog2(FRAME_SIZE);
	// wide enough for x + FRAME_WIDTH*y with full-byte x and y
	localparam int IW = 8 + $clog2(FRAME_WIDTH + 1);

	ctl_t          ctl;
	logic          rx_xfer;
	logic          complete;
	logic [7:0]    cmd;
	logic [7:0]    set_x;
	logic [7:0]    set_y;
	logic [23:0]   set_color;
	logic [IW-1:0] set_idx;
	logic          in_range;
	logic [AW-1:0] addr;
	logic [2:0]    pix_x;
	logic [2:0]    pix_y;
	logic          at_end;
	logic [23:0]   mem_rdata;
	logic          slot_free;

	// output register
	logic          result_valid_q;
	kind_t         kind_q;
	logic [2:0]    pixel_x_q;
	logic [2:0]    pixel_y_q;
	logic [23:0]   pixel_color_q;
	logic          final_q;

	assign rx_ready  = ctl.rx_ready;
	assign rx_xfer   = rx_valid && ctl.rx_ready;
	assign slot_free = !result_valid_q || result_ready;

	// set-pixel target index; anything past the frame is dropped
	assign set_idx  = IW'(set_x) + IW'(FRAME_WIDTH) * IW'(set_y);
	assign in_range = set_idx < IW'(FRAME_SIZE);

	spcf_pkt_store #(
		.PACKET_CAPACITY(PACKET_CAPACITY)
	) u_pkt (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (rx_xfer),
		.wr_byte  (rx_byte),
		.pos_clr  (ctl.pos_clr),
		.complete (complete),
		.cmd      (cmd),
		.set_x    (set_x),
		.set_y    (set_y),
		.set_color(set_color)
	);

	// one address unit serves the clear sweep, the pixel write and the readout
	spcf_addr_unit #(
		.FRAME_WIDTH (FRAME_WIDTH),
		.FRAME_HEIGHT(FRAME_HEIGHT)
	) u_addr (
		.clk      (clk),
		.arst_n   (arst_n),
		.aop      (ctl.aop),
		.load_addr(set_idx[AW-1:0]),
		.addr     (addr),
		.pix_x    (pix_x),
		.pix_y    (pix_y),
		.at_end   (at_end)
	);

	spcf_frame_mem #(
		.DEPTH(FRAME_SIZE)
	) u_mem (
		.clk  (clk),
		.we   (ctl.mem_we),
		.re   (ctl.mem_re),
		.addr (addr),
		.wdata(ctl.mem_zero ? 24'd0 : set_color),
		.rdata(mem_rdata)
	);

	spcf_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx_valid),
		.complete (complete),
		.cmd      (cmd),
		.in_range (in_range),
		.at_end   (at_end),
		.slot_free(slot_free),
		.ctl      (ctl)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	// non-pixel results carry zero coordinates and colour
	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			kind_q  <= ctl.out_kind;
			final_q <= ctl.out_final;
			if (ctl.out_kind == KIND_PIXEL) begin
				pixel_x_q     <= pix_x;
				pixel_y_q     <= pix_y;
				pixel_color_q <= mem_rdata;
			end else begin
				pixel_x_q     <= 3'd0;
				pixel_y_q     <= 3'd0;
				pixel_color_q <= 24'd0;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign kind         = kind_q;
	assign pixel_x      = pixel_x_q;
	assign pixel_y      = pixel_y_q;
	assign pixel_color  = pixel_color_q;
	assign acknowledge  = final_q;
	assign last         = final_q;

	`SPCF_ASSERT_NEXT(a_busy_after_rx, rx_xfer, !rx_ready, "rx_ready high right after a byte transfer")
	`SPCF_ASSERT_SAME(a_readout_end, result_valid_q && kind_q == KIND_PIXEL && final_q, pixel_x_q == 3'(FRAME_WIDTH - 1) && pixel_y_q == 3'(FRAME_HEIGHT - 1), "readout ended off the last pixel")
	`SPCF_ASSERT_SAME(a_ack_payload, result_valid_q && kind_q != KIND_PIXEL, final_q && pixel_color_q == 24'd0 && pixel_x_q == 3'd0 && pixel_y_q == 3'd0, "acknowledge result with stray payload")

endmodule

@@ src/spcf_pkt_store.sv @@
// Packet byte store, running position and completion detect.
module spcf_pkt_store import spcf_pkg::*; #(
	parameter int PACKET_CAPACITY = PACKET_CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [7:0]  wr_byte,
	input  logic        pos_clr,
	output logic        complete,
	output logic [7:0]  cmd,
	output logic [7:0]  set_x,
	output logic [7:0]  set_y,
	output logic [23:0] set_color
);

	localparam int PW  = $clog2(PACKET_CAPACITY + 1);
	localparam int PIW = $clog2(PACKET_CAPACITY);

	logic [7:0]    bytes_q [PACKET_CAPACITY];
	logic [PW-1:0] pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			for (int i = 0; i < PACKET_CAPACITY; i++) begin
				bytes_q[i] <= 8'd0;
			end
		end else begin
			if (wr_en) begin
				bytes_q[pos_q[PIW-1:0]] <= wr_byte;
				pos_q <= pos_q + PW'(1);
			end else if (pos_clr) begin
				pos_q <= '0;
			end
		end
	end

	// pos_q already holds the position after the write
	assign complete  = (8'(pos_q) == bytes_q[0]) || (pos_q == PW'(PACKET_CAPACITY));
	assign cmd       = bytes_q[1];
	assign set_x     = bytes_q[2];
	assign set_y     = bytes_q[3];
	assign set_color = {bytes_q[4], bytes_q[5], bytes_q[6]};

endmodule

@@ src/spcf_addr_unit.sv @@
// Shared frame address counter with raster coordinates and end compare.
module spcf_addr_unit import spcf_pkg::*; #(
	parameter int FRAME_WIDTH  = FRAME_WIDTH_DEF,
	parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  aop_t                                        aop,
	input  logic [$clog2(FRAME_WIDTH*FRAME_HEIGHT)-1:0] load_addr,
	output logic [$clog2(FRAME_WIDTH*FRAME_HEIGHT)-1:0] addr,
	output logic [2:0]                                  pix_x,
	output logic [2:0]                                  pix_y,
	output logic                                        at_end
);

	localparam int FRAME_SIZE = FRAME_WIDTH * FRAME_HEIGHT;
	localparam int AW = $clog2(FRAME_SIZE);
	localparam int XW = $clog2(FRAME_WIDTH);
	localparam int YW = $clog2(FRAME_HEIGHT);

	logic [AW-1:0] addr_q;
	logic [XW-1:0] x_q;
	logic [YW-1:0] y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
			x_q    <= '0;
			y_q    <= '0;
		end else begin
			case (aop)
				AOP_ZERO: begin
					addr_q <= '0;
					x_q    <= '0;
					y_q    <= '0;
				end
				AOP_LOAD: begin
					addr_q <= load_addr;
				end
				AOP_STEP: begin
					addr_q <= addr_q + AW'(1);
					if (x_q == XW'(FRAME_WIDTH - 1)) begin
						x_q <= '0;
						y_q <= y_q + YW'(1);
					end else begin
						x_q <= x_q + XW'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign addr   = addr_q;
	assign pix_x  = 3'(x_q);
	assign pix_y  = 3'(y_q);
	assign at_end = (addr_q == AW'(FRAME_SIZE - 1));

endmodule

@@ src/spcf_frame_mem.sv @@
// Frame pixel memory, one port, registered read data.
module spcf_frame_mem import spcf_pkg::*; #(
	parameter int DEPTH = FRAME_WIDTH_DEF * FRAME_HEIGHT_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [23:0]              wdata,
	output logic [23:0]              rdata
);

	logic [23:0] mem_q [DEPTH];
	logic [23:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ src/spcf_seq.sv @@
// Sequencer for byte intake, command dispatch, clear sweep and readout.
module spcf_seq import spcf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rx_valid,
	input  logic       complete,
	input  logic [7:0] cmd,
	input  logic       in_range,
	input  logic       at_end,
	input  logic       slot_free,
	output ctl_t       ctl
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (at_end) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (rx_valid) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (!complete) begin
					state_d = ST_IDLE;
				end else if (cmd == CMD_READOUT) begin
					state_d = ST_RDADDR;
				end else if (cmd == CMD_SET) begin
					state_d = ST_WRITE;
				end else begin
					state_d = ST_ACK;
				end
			end
			ST_WRITE: state_d = ST_ACK;
			ST_ACK: begin
				if (slot_free) state_d = ST_IDLE;
			end
			ST_RDADDR: state_d = ST_EMIT;
			ST_EMIT: begin
				if (slot_free) state_d = at_end ? ST_IDLE : ST_RDADDR;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		ctl = '0;
		ctl.aop = AOP_HOLD;
		ctl.out_kind = KIND_ACK;
		case (state_q)
			ST_CLEAR: begin
				ctl.mem_we   = 1'b1;
				ctl.mem_zero = 1'b1;
				ctl.aop      = at_end ? AOP_ZERO : AOP_STEP;
			end
			ST_IDLE: begin
				ctl.rx_ready = 1'b1;
			end
			ST_CHECK: begin
				if (complete) begin
					ctl.pos_clr = 1'b1;
					if (cmd == CMD_READOUT) begin
						ctl.aop = AOP_ZERO;
					end else if (cmd == CMD_SET) begin
						ctl.aop = AOP_LOAD;
					end
				end
			end
			ST_WRITE: begin
				// out-of-range writes are dropped
				ctl.mem_we = in_range;
				ctl.aop    = AOP_ZERO;
			end
			ST_ACK: begin
				ctl.out_load  = slot_free;
				ctl.out_final = 1'b1;
				ctl.out_kind  = (cmd == CMD_START || cmd == CMD_SET) ? KIND_ACK : KIND_BAD;
			end
			ST_RDADDR: begin
				ctl.mem_re = 1'b1;
			end
			ST_EMIT: begin
				ctl.out_load  = slot_free;
				ctl.out_kind  = KIND_PIXEL;
				ctl.out_final = at_end;
				if (slot_free) ctl.aop = at_end ? AOP_ZERO : AOP_STEP;
			end
			default: begin
			end
		endcase
	end

endmodule
